// ===== src/decimating_trace_ring_buffer_top_defines.svh =====
// Assertion macros for the trace ring buffer.
`ifndef DECIMATING_TRACE_RING_BUFFER_TOP_DEFINES_SVH
`define DECIMATING_TRACE_RING_BUFFER_TOP_DEFINES_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define DTRB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtrb same-cycle check failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define DTRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtrb next-cycle check failed");

`endif

// ===== src/dtrb_pkg.sv =====
package dtrb_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int CHANNELS_DEF    = 4;
   localparam int WORD_BITS_DEF   = 32;

   localparam int FIELD_BITS    = 32;
   localparam int POS_BITS      = 10;
   localparam int HELD_BITS     = 11;
   localparam int INTERVAL_BITS = 8;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 8'd2;
   localparam logic [FIELD_BITS-1:0]    MARKER_RESET   = 32'd0;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_INTERVAL  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STOP_MARKER_WORD = 1'd1;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_STOP   = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_FETCH = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      func_type              func;
      logic [FIELD_BITS-1:0] chan0_word;
      logic [FIELD_BITS-1:0] chan1_word;
      logic [FIELD_BITS-1:0] chan2_word;
      logic [FIELD_BITS-1:0] chan3_word;
      logic [POS_BITS-1:0]   read_position;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] out_chan0;
      logic [FIELD_BITS-1:0] out_chan1;
      logic [FIELD_BITS-1:0] out_chan2;
      logic [FIELD_BITS-1:0] out_chan3;
      logic                  entry_valid;
      logic [HELD_BITS-1:0]  entries_held;
      logic                  has_wrapped;
   } rsp_type;

   typedef struct packed {
      logic sample;
      logic stop;
      logic read;
      logic clear;
      logic load;
   } cmd_type;

endpackage

// ===== src/dtrb_ctrl.sv =====
module dtrb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  dtrb_pkg::func_type  req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dtrb_pkg::cmd_type   cmd
);

   dtrb_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtrb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtrb_pkg::ST_IDLE: begin
            if (req_valid && req_func == dtrb_pkg::FUNC_READ) begin
               state_in = dtrb_pkg::ST_FETCH;
            end
         end
         dtrb_pkg::ST_FETCH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = dtrb_pkg::ST_IDLE;
            end
         end
         default: state_in = dtrb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b0;
      accept     = 1'b0;
      cmd        = '0;
      case (state_ff)
         dtrb_pkg::ST_IDLE: begin
            accept     = req_valid;
            cmd.sample = accept && req_func == dtrb_pkg::FUNC_SAMPLE;
            cmd.stop   = accept && req_func == dtrb_pkg::FUNC_STOP;
            cmd.read   = accept && req_func == dtrb_pkg::FUNC_READ;
            cmd.clear  = accept && req_func == dtrb_pkg::FUNC_CLEAR;
         end
         dtrb_pkg::ST_FETCH: begin
            req_stall = 1'b1;
            cmd.load  = !rsp_valid_ff || !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/dtrb_datapath.sv =====
module dtrb_datapath #(
   parameter int STORE_DEPTH = dtrb_pkg::STORE_DEPTH_DEF,
   parameter int CHANNELS    = dtrb_pkg::CHANNELS_DEF,
   parameter int WORD_BITS   = dtrb_pkg::WORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [dtrb_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dtrb_pkg::FIELD_BITS-1:0]      csr_wdata,
   input  dtrb_pkg::req_type                    req_payload,
   input  dtrb_pkg::cmd_type                    cmd,
   output dtrb_pkg::rsp_type                    rsp_payload
);

   localparam int PW = $clog2(STORE_DEPTH);
   localparam int HW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (HW > dtrb_pkg::POS_BITS) ? HW : dtrb_pkg::POS_BITS;
   localparam int MW = CHANNELS * WORD_BITS;
   localparam int IB = dtrb_pkg::INTERVAL_BITS;
   localparam int FB = dtrb_pkg::FIELD_BITS;

   logic [MW-1:0] mem [STORE_DEPTH];

   logic [PW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;
   logic [IB-1:0] count_ff, count_in;
   logic          marker_ff, marker_in;
   logic [IB-1:0] interval_ff, interval_in;
   logic [FB-1:0] mword_ff, mword_in;

   logic [MW-1:0] rd_word_ff;
   logic          rd_valid_ff;
   logic [dtrb_pkg::HELD_BITS-1:0] rd_held_ff;
   logic          rd_wrapped_ff;
   dtrb_pkg::rsp_type rsp_ff, rsp_in;

   logic [IB-1:0] ivl, dec_mod;
   logic          kept, do_cap, wr_en;
   logic [MW-1:0] wr_data;
   logic [FB-1:0] in_words [4];
   logic [HW-1:0] held;
   logic [CW-1:0] pos_ext;
   logic          pos_valid;
   logic [PW:0]   slot_sum;
   logic [PW-1:0] rd_slot;
   logic [FB-1:0] out_words [4];

   // decimation
   always_comb begin
      ivl     = (interval_ff == '0) ? IB'(1) : interval_ff;
      dec_mod = (count_ff >= ivl) ? count_ff - ivl : count_ff;
      kept    = (dec_mod == '0);
      do_cap  = cmd.sample || (cmd.stop && !marker_ff);
      wr_en   = do_cap && kept;
   end

   always_comb begin
      in_words[0] = req_payload.chan0_word;
      in_words[1] = req_payload.chan1_word;
      in_words[2] = req_payload.chan2_word;
      in_words[3] = req_payload.chan3_word;
      for (int c = 0; c < CHANNELS; c++) begin
         wr_data[c*WORD_BITS +: WORD_BITS] = cmd.stop ? WORD_BITS'(mword_ff)
                                                      : WORD_BITS'(in_words[c]);
      end
   end

   // state update
   always_comb begin
      wp_in       = wp_ff;
      wrapped_in  = wrapped_ff;
      count_in    = count_ff;
      marker_in   = marker_ff;
      interval_in = interval_ff;
      mword_in    = mword_ff;
      if (do_cap) begin
         count_in = dec_mod + IB'(1);
      end
      if (wr_en) begin
         if (wp_ff == PW'(STORE_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + PW'(1);
         end
      end
      if (cmd.sample) begin
         marker_in = 1'b0;
      end else if (cmd.stop && wr_en) begin
         marker_in = 1'b1;
      end
      if (cmd.clear) begin
         wp_in      = '0;
         wrapped_in = 1'b0;
         count_in   = '0;
         marker_in  = 1'b0;
      end
      if (csr_write_en) begin
         case (csr_index)
            dtrb_pkg::CSR_SAMPLE_INTERVAL: begin
               interval_in = csr_wdata[IB-1:0];
               count_in    = '0;
            end
            dtrb_pkg::CSR_STOP_MARKER_WORD: mword_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         wrapped_ff  <= 1'b0;
         count_ff    <= '0;
         marker_ff   <= 1'b0;
         interval_ff <= dtrb_pkg::INTERVAL_RESET;
         mword_ff    <= dtrb_pkg::MARKER_RESET;
      end else begin
         wp_ff       <= wp_in;
         wrapped_ff  <= wrapped_in;
         count_ff    <= count_in;
         marker_ff   <= marker_in;
         interval_ff <= interval_in;
         mword_ff    <= mword_in;
      end
   end

   // read address
   always_comb begin
      held      = wrapped_ff ? HW'(STORE_DEPTH) : HW'(wp_ff);
      pos_ext   = CW'(req_payload.read_position);
      pos_valid = pos_ext < CW'(held);
      slot_sum  = (PW+1)'(wp_ff) + (PW+1)'(pos_ext[PW-1:0]);
      if (!wrapped_ff) begin
         rd_slot = pos_ext[PW-1:0];
      end else if (slot_sum >= (PW+1)'(STORE_DEPTH)) begin
         rd_slot = PW'(slot_sum - (PW+1)'(STORE_DEPTH));
      end else begin
         rd_slot = slot_sum[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (cmd.read) begin
         rd_word_ff    <= mem[rd_slot];
         rd_valid_ff   <= pos_valid;
         rd_held_ff    <= dtrb_pkg::HELD_BITS'(held);
         rd_wrapped_ff <= wrapped_ff;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_out
      if (k < CHANNELS) begin : g_live
         assign out_words[k] = rd_valid_ff ? FB'(rd_word_ff[k*WORD_BITS +: WORD_BITS]) : '0;
      end else begin : g_zero
         assign out_words[k] = '0;
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      if (cmd.load) begin
         rsp_in.out_chan0    = out_words[0];
         rsp_in.out_chan1    = out_words[1];
         rsp_in.out_chan2    = out_words[2];
         rsp_in.out_chan3    = out_words[3];
         rsp_in.entry_valid  = rd_valid_ff;
         rsp_in.entries_held = rd_held_ff;
         rsp_in.has_wrapped  = rd_wrapped_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== src/decimating_trace_ring_buffer_top.sv =====
// Decimating trace ring buffer.
// Input channel (req_valid / req_stall / req_payload) carries one word per item:
// func selects sample, stop marker, read entry or clear capture. Samples and
// stop markers pass a decimator that keeps one of sample_interval records and
// writes it into a circular store of STORE_DEPTH entries.
// Result channel (rsp_valid / rsp_stall / rsp_payload) returns one word per
// read item: the entry at a chronological position (oldest first), its valid
// flag, the number of entries held and the wrapped flag. Other items give none.
// Sample, stop and clear items are accepted back to back.
// A read item first reads the store into a read register, then the result is
// moved into the output register and rsp_valid is raised. A read that finds
// the output register still full waits in the fetch state, holding req_stall
// high, until the receiver takes the old result.
// Configuration is a plain write port (csr_write_en, csr_index, csr_wdata);
// write it only while the block is idle.
// Synchronous reset clears the pointer, wrap, decimation and marker state and
// sets the interval to 2 and the marker word to 0. Store contents are not
// cleared; only written entries are ever reachable through valid positions.
`include "decimating_trace_ring_buffer_top_defines.svh"

module decimating_trace_ring_buffer_top #(
   parameter int STORE_DEPTH = dtrb_pkg::STORE_DEPTH_DEF,
   parameter int CHANNELS    = dtrb_pkg::CHANNELS_DEF,
   parameter int WORD_BITS   = dtrb_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dtrb_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dtrb_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_en,
   input  logic [dtrb_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [dtrb_pkg::FIELD_BITS-1:0]   csr_wdata
);

   dtrb_pkg::cmd_type cmd;

   dtrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_payload.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dtrb_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .CHANNELS    (CHANNELS),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .cmd          (cmd),
      .rsp_payload  (rsp_payload)
   );

   `DTRB_ASSERT_NEXT(a_read_blocks_next, clock, reset,
      req_valid && !req_stall && req_payload.func == dtrb_pkg::FUNC_READ, req_stall)
   `DTRB_ASSERT_SAME(a_invalid_reads_zero, clock, reset,
      rsp_valid && !rsp_payload.entry_valid,
      rsp_payload.out_chan0 == '0 && rsp_payload.out_chan3 == '0)
   `DTRB_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load, rsp_valid)

endmodule

// ===== sim/decimating_trace_ring_buffer_top_test.sv =====
module decimating_trace_ring_buffer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dtrb_pkg::*;

   localparam int DEPTH = STORE_DEPTH_DEF;

   typedef struct packed {
      func_type              func;
      logic [FIELD_BITS-1:0] c0;
      logic [FIELD_BITS-1:0] c1;
      logic [FIELD_BITS-1:0] c2;
      logic [FIELD_BITS-1:0] c3;
      logic [POS_BITS-1:0]   pos;
      logic                  typed;
      rsp_type               want;
   } row_type;

   localparam rsp_type NONE       = '0;
   localparam rsp_type EMPTY_READ = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0};
   localparam rsp_type FIRST_ONES = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 1'b1, 11'd2, 1'b0};
   localparam rsp_type PAST_TWO   = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd2, 1'b0};
   localparam rsp_type PAST_FIVE  = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd5, 1'b0};

   // reset settings: interval 2, marker word 0
   localparam row_type DIRECTED_ROWS [0:23] = '{
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, EMPTY_READ},
      '{FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        10'd1023, 1'b1, EMPTY_READ},
      '{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        10'd1023, 1'b0, NONE},
      '{FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_SAMPLE, 32'h8000_0001, 32'h7FFF_FFFE, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
        10'd0, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, FIRST_ONES},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd1, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd2, 1'b1, PAST_TWO},
      '{FUNC_STOP, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444,
        10'd0, 1'b0, NONE},
      '{FUNC_STOP, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_STOP, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_STOP, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd2, 1'b0, NONE},
      '{FUNC_SAMPLE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        10'd0, 1'b0, NONE},
      '{FUNC_STOP, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_SAMPLE, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0000_0001, 32'h8000_0000,
        10'd0, 1'b0, NONE},
      '{FUNC_SAMPLE, 32'h0BAD_F00D, 32'h7777_7777, 32'hFFFF_0000, 32'h0000_FFFF,
        10'd0, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd1023, 1'b1, PAST_FIVE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd4, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd3, 1'b0, NONE},
      '{FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b1, EMPTY_READ},
      '{FUNC_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF,
        10'd0, 1'b0, NONE},
      '{FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1'b0, NONE}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_payload;
   logic                    csr_write_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [FIELD_BITS-1:0]   csr_wdata;

   decimating_trace_ring_buffer_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // expected trace state
   bit [31:0] trace_mem [DEPTH][4];
   bit [9:0]  wr_ptr       = '0;
   bit        wrapped      = 1'b0;
   bit [7:0]  dec_count    = '0;
   bit        marker_done  = 1'b0;
   bit [7:0]  keep_every   = INTERVAL_RESET;
   bit [31:0] marker_word  = MARKER_RESET;

   rsp_type   pending_reads [$];
   int        err_count    = 0;
   bit        idling_on    = 1'b1;
   int        stall_left   = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL decimating_trace_ring_buffer_top");
      $finish;
   end

   task automatic flag_error(string msg);
      $display("ERROR %0t: %0s", $time, msg);
      err_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%0s got %h want %h", name, got, want));
   endtask

   function automatic bit keep_record(bit [31:0] w0, bit [31:0] w1,
                                      bit [31:0] w2, bit [31:0] w3);
      bit [7:0] ivl;
      bit       kept;
      ivl = (keep_every == 0) ? 8'd1 : keep_every;
      dec_count = dec_count % ivl;
      kept = (dec_count == 0);
      if (kept) begin
         trace_mem[wr_ptr][0] = w0;
         trace_mem[wr_ptr][1] = w1;
         trace_mem[wr_ptr][2] = w2;
         trace_mem[wr_ptr][3] = w3;
         if (wr_ptr == DEPTH - 1)
            wrapped = 1'b1;
         wr_ptr = wr_ptr + 1'b1;
      end
      dec_count = dec_count + 1'b1;
      return kept;
   endfunction

   task automatic predict_trace(input req_type w, output bit has_rsp, output rsp_type r);
      bit [10:0] held;
      bit [9:0]  slot;
      has_rsp = 1'b0;
      r = '0;
      case (w.func)
         FUNC_SAMPLE: begin
            void'(keep_record(w.chan0_word, w.chan1_word, w.chan2_word, w.chan3_word));
            marker_done = 1'b0;
         end
         FUNC_STOP: begin
            if (!marker_done) begin
               if (keep_record(marker_word, marker_word, marker_word, marker_word))
                  marker_done = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            wr_ptr = '0;
            wrapped = 1'b0;
            dec_count = '0;
            marker_done = 1'b0;
         end
         default: begin
            held = wrapped ? 11'(DEPTH) : {1'b0, wr_ptr};
            has_rsp = 1'b1;
            r.entry_valid = ({1'b0, w.read_position} < held);
            r.entries_held = held;
            r.has_wrapped = wrapped;
            if (r.entry_valid) begin
               slot = wrapped ? wr_ptr + w.read_position : w.read_position;
               r.out_chan0 = trace_mem[slot][0];
               r.out_chan1 = trace_mem[slot][1];
               r.out_chan2 = trace_mem[slot][2];
               r.out_chan3 = trace_mem[slot][3];
            end
         end
      endcase
   endtask

   task automatic send_word(req_type w, bit typed, rsp_type want);
      bit      has_rsp;
      rsp_type pred;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
      predict_trace(w, has_rsp, pred);
      if (has_rsp)
         pending_reads.push_back(typed ? want : pred);
   endtask

   // drain all reads, then give the registered read path time to go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, bit [31:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_SAMPLE_INTERVAL) begin
         keep_every = data[7:0];
         dec_count = '0;
      end else begin
         marker_word = data;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic bit [31:0] pick_chan();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [9:0] pick_position();
      int held;
      held = wrapped ? DEPTH : int'(wr_ptr);
      case ($urandom_range(0, 7))
         0: return 10'($urandom);
         1: return 10'd1023;
         2: return (held < DEPTH) ? 10'(held) : 10'd0;
         3: return (held > 0) ? 10'(held - 1) : 10'd0;
         default: return (held > 0) ? 10'($urandom_range(0, held - 1)) : 10'($urandom);
      endcase
   endfunction

   function automatic req_type make_item(int w_sample, int w_stop, int w_read, int w_clear);
      req_type w;
      int      roll;
      roll = $urandom_range(0, w_sample + w_stop + w_read + w_clear - 1);
      if (roll < w_sample)
         w.func = FUNC_SAMPLE;
      else if (roll < w_sample + w_stop)
         w.func = FUNC_STOP;
      else if (roll < w_sample + w_stop + w_read)
         w.func = FUNC_READ;
      else
         w.func = FUNC_CLEAR;
      w.chan0_word = pick_chan();
      w.chan1_word = pick_chan();
      w.chan2_word = pick_chan();
      w.chan3_word = pick_chan();
      w.read_position = pick_position();
      return w;
   endfunction

   always @(negedge clock) begin
      if (idling_on && stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            flag_error("result word with no read outstanding");
         end else begin
            want = pending_reads.pop_front();
            check_field("out_chan0", rsp_payload.out_chan0, want.out_chan0);
            check_field("out_chan1", rsp_payload.out_chan1, want.out_chan1);
            check_field("out_chan2", rsp_payload.out_chan2, want.out_chan2);
            check_field("out_chan3", rsp_payload.out_chan3, want.out_chan3);
            check_field("entry_valid", 32'(rsp_payload.entry_valid), 32'(want.entry_valid));
            check_field("entries_held", 32'(rsp_payload.entries_held),
                        32'(want.entries_held));
            check_field("has_wrapped", 32'(rsp_payload.has_wrapped), 32'(want.has_wrapped));
         end
      end
   end

   initial begin
      bit [7:0]  intervals [4];
      int        counts [4];
      req_type   w;
      row_type   row;

      intervals    = '{8'd255, 8'd0, 8'd3, 8'd1};
      counts       = '{120, 80, 120, 100};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SAMPLE_INTERVAL;
      csr_wdata    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         w.func          = row.func;
         w.chan0_word    = row.c0;
         w.chan1_word    = row.c1;
         w.chan2_word    = row.c2;
         w.chan3_word    = row.c3;
         w.read_position = row.pos;
         send_word(w, row.typed, row.want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         if (ph == 3)
            idling_on = 1'b0;
         write_csr(CSR_SAMPLE_INTERVAL,
                   (ph == 3) ? 32'($urandom_range(1, 8)) : 32'(intervals[ph]));
         write_csr(CSR_STOP_MARKER_WORD,
                   (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'h0 : $urandom);
         for (int n = 0; n < counts[ph]; n++)
            send_word(make_item(50, 20, 27, 3), 1'b0, NONE);
      end

      settle();
      repeat (10) @(posedge clock);
      if (err_count == 0 && pending_reads.size() == 0)
         $display("PASS decimating_trace_ring_buffer_top");
      else
         $display("FAIL decimating_trace_ring_buffer_top");
      $finish;
   end

endmodule
